@@ rtl/core/pdsos_pkg.sv @@
package pdsos_pkg;

    localparam int MAX_OFFERS = 7;

    localparam int UNIT_W  = 10;   // voltage and current field width of a fixed PDO
    localparam int POWER_W = 20;
    localparam int POS_W   = 3;

    // PDO type field value for a fixed supply
    localparam logic [1:0] PDO_TYPE_FIXED = 2'b00;

    // 20000 mV in 50 mV units
    localparam logic [UNIT_W-1:0] START_VOLTAGE_UNITS = 10'd400;
    // 100 mA in 10 mA units
    localparam logic [UNIT_W-1:0] FALLBACK_UNITS      = 10'd10;
    localparam logic [POS_W-1:0]  FALLBACK_POSITION   = 3'd1;

    localparam logic [POS_W-1:0]  COUNT_LIMIT = POS_W'(MAX_OFFERS - 1);

    localparam logic [15:0] HDR_REQUEST_TYPE = 16'h0002;
    localparam logic [15:0] HDR_ONE_OBJECT   = 16'h1000;

    localparam int RDO_MISMATCH_BIT   = 26;
    localparam int RDO_NO_SUSPEND_BIT = 24;

    function automatic logic [31:0] make_rdo(
        input logic [POS_W-1:0]  position,
        input logic [UNIT_W-1:0] units,
        input logic              mismatch
    );
        return {1'b0, position, 1'b0, mismatch, 1'b0, 1'b1, 4'b0000, units, units};
    endfunction

endpackage

@@ rtl/core/pd_source_offer_selector_unit.sv @@
// USB PD sink offer selector.
// Offer channel: one source power data object per transfer (i_offer_word),
// i_last_offer marks the final object of a capabilities message. Fixed-supply
// objects are scored by power (rounded mW); the highest wins, equal power goes
// to the lower voltage, a full tie to the later object.
// Request channel: one transfer per message, on its last object, carrying the
// request header, the request data object and o_matched (0 = fallback request
// for position 1 at 100 mA with the capability mismatch bit set).
// Config channel: writes header_template, ORed into the request header; write
// it only while no message is in flight. o_cfg_ready is always high.
// The last object's transfer loads the input register, then a single 10x10
// multiply and compare load the result register, which drives the request.
// Throughput: one object per cycle while no last object is held back by a stall.
// When the request receiver stalls, a last object waits in the input register
// and o_offer_ready drops only then; non-last objects keep flowing.
// Reset (synchronous, active low) clears the search state, the template and
// both valid flags.
module pd_source_offer_selector_unit
    import pdsos_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_header_template,

    input  logic        i_offer_valid,
    output logic        o_offer_ready,
    input  logic [31:0] i_offer_word,
    input  logic        i_last_offer,

    output logic        o_req_valid,
    input  logic        i_req_ready,
    output logic [15:0] o_request_header,
    output logic [31:0] o_request_object,
    output logic        o_matched
);

    logic [15:0]        r_header_template;

    logic               r_s1_valid;
    logic [31:0]        r_s1_word;
    logic               r_s1_last;

    logic [POWER_W-1:0] r_best_power,    n_best_power;
    logic [UNIT_W-1:0]  r_best_voltage,  n_best_voltage;
    logic [UNIT_W-1:0]  r_best_current,  n_best_current;
    logic [POS_W-1:0]   r_best_position, n_best_position;
    logic               r_found_any,     n_found_any;
    logic [POS_W-1:0]   r_offer_count;

    logic               r_out_valid;
    logic [15:0]        r_out_header;
    logic [31:0]        r_out_object;
    logic               r_out_matched;

    logic               out_free;
    logic               s1_go;
    logic               is_fixed;
    logic [UNIT_W-1:0]  volt_units;
    logic [UNIT_W-1:0]  curr_units;
    logic [POWER_W:0]   prod_plus;
    logic [POWER_W-1:0] power_mw;
    logic               take;
    logic [POS_W-1:0]   position;

    assign o_cfg_ready = 1'b1;

    assign out_free      = !r_out_valid || i_req_ready;
    assign s1_go         = r_s1_valid && (!r_s1_last || out_free);
    assign o_offer_ready = !r_s1_valid || s1_go;

    assign is_fixed   = (r_s1_word[31:30] == PDO_TYPE_FIXED);
    assign volt_units = r_s1_word[19:10];
    assign curr_units = r_s1_word[9:0];
    // (v*50 mV * c*10 mA + 500) / 1000 reduces to (v*c + 1) / 2
    assign prod_plus  = (POWER_W+1)'(volt_units) * (POWER_W+1)'(curr_units) + 1'b1;
    assign power_mw   = prod_plus[POWER_W:1];
    assign position   = r_offer_count + 1'b1;

    assign take = is_fixed &&
                  !((power_mw < r_best_power) ||
                    (power_mw == r_best_power && volt_units > r_best_voltage));

    always_comb begin
        n_best_power    = r_best_power;
        n_best_voltage  = r_best_voltage;
        n_best_current  = r_best_current;
        n_best_position = r_best_position;
        n_found_any     = r_found_any;
        if (take) begin
            n_best_power    = power_mw;
            n_best_voltage  = volt_units;
            n_best_current  = curr_units;
            n_best_position = position;
            n_found_any     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_template <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_header_template <= i_cfg_header_template;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_offer_ready) begin
            r_s1_valid <= i_offer_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_offer_valid && o_offer_ready) begin
            r_s1_word <= i_offer_word;
            r_s1_last <= i_last_offer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_power    <= '0;
            r_best_voltage  <= START_VOLTAGE_UNITS;
            r_best_current  <= '0;
            r_best_position <= '0;
            r_found_any     <= 1'b0;
            r_offer_count   <= '0;
        end else if (s1_go) begin
            if (r_s1_last) begin
                // restart the search for the next message
                r_best_power    <= '0;
                r_best_voltage  <= START_VOLTAGE_UNITS;
                r_best_current  <= '0;
                r_best_position <= '0;
                r_found_any     <= 1'b0;
                r_offer_count   <= '0;
            end else begin
                r_best_power    <= n_best_power;
                r_best_voltage  <= n_best_voltage;
                r_best_current  <= n_best_current;
                r_best_position <= n_best_position;
                r_found_any     <= n_found_any;
                if (r_offer_count < COUNT_LIMIT) begin
                    r_offer_count <= r_offer_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_req_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_header  <= r_header_template | HDR_REQUEST_TYPE | HDR_ONE_OBJECT;
            r_out_matched <= n_found_any;
            if (n_found_any) begin
                r_out_object <= make_rdo(n_best_position, n_best_current, 1'b0);
            end else begin
                r_out_object <= make_rdo(FALLBACK_POSITION, FALLBACK_UNITS, 1'b1);
            end
        end
    end

    assign o_req_valid      = r_out_valid;
    assign o_request_header = r_out_header;
    assign o_request_object = r_out_object;
    assign o_matched        = r_out_matched;

endmodule

@@ rtl/core/pdsos_checker.sv @@
module pdsos_checker
    import pdsos_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_offer_valid,
    input  logic        o_offer_ready,
    input  logic        i_last_offer,
    input  logic        o_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] o_request_header,
    input  logic [31:0] o_request_object,
    input  logic        o_matched
);

    // a request held by the receiver keeps its contents
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req_valid && !i_req_ready) |=>
            (o_req_valid && $stable(o_request_object) && $stable(o_matched)
             && $stable(o_request_header)))
        else $error("request changed while stalled");

    // every request header has the request type and one-object bits set
    a_hdr_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_valid |-> ((o_request_header & (HDR_REQUEST_TYPE | HDR_ONE_OBJECT))
                         == (HDR_REQUEST_TYPE | HDR_ONE_OBJECT)))
        else $error("request header missing type or count");

    // fallback requests position 1 at 100 mA with mismatch set
    a_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req_valid && !o_matched) |->
            (o_request_object == make_rdo(FALLBACK_POSITION, FALLBACK_UNITS, 1'b1)))
        else $error("bad fallback request object");

    // a matched request names a real position, clears mismatch and sets no-suspend
    a_matched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req_valid && o_matched) |->
            (o_request_object[30:28] != 3'd0 && !o_request_object[RDO_MISMATCH_BIT]
             && o_request_object[RDO_NO_SUSPEND_BIT]))
        else $error("bad matched request object");

    // a request can only follow a last-object transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_req_valid) |-> $past(i_offer_valid && o_offer_ready && i_last_offer, 2)
            || $past(!o_offer_ready, 1))
        else $error("request without a last object");

endmodule

bind pd_source_offer_selector_unit pdsos_checker u_pdsos_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import pdsos_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam logic [15:0] START_MV = 16'(START_VOLTAGE_UNITS * 50);

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } offer_t;

    typedef struct packed {
        logic [15:0] header;
        logic [31:0] rdo;
        logic        matched;
    } request_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_header_template = '0;
    logic        i_offer_valid = 1'b0;
    logic [31:0] i_offer_word = '0;
    logic        i_last_offer = 1'b0;
    logic        i_req_ready = 1'b0;
    logic        o_cfg_ready;
    logic        o_offer_ready;
    logic        o_req_valid;
    logic [15:0] o_request_header;
    logic [31:0] o_request_object;
    logic        o_matched;

    pd_source_offer_selector_unit i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_header_template (i_cfg_header_template),
        .i_offer_valid         (i_offer_valid),
        .o_offer_ready         (o_offer_ready),
        .i_offer_word          (i_offer_word),
        .i_last_offer          (i_last_offer),
        .o_req_valid           (o_req_valid),
        .i_req_ready           (i_req_ready),
        .o_request_header      (o_request_header),
        .o_request_object      (o_request_object),
        .o_matched             (o_matched)
    );

    // stimulus and expectations
    offer_t   offer_queue[$];
    request_t pending_requests[$];

    // selector state as the block should hold it
    logic [15:0] header_bits = '0;
    logic [19:0] best_mw = '0;
    logic [15:0] best_mv = START_MV;
    logic [13:0] best_ma = '0;
    logic [2:0]  best_pos = '0;
    logic        found_fixed = 1'b0;
    logic [2:0]  objects_seen = '0;

    // idling control
    logic calm = 1'b0;
    logic start_hold = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   stall_left = 0;
    int   gap_left = 0;
    int   mismatches = 0;
    int   cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // score one object and, on the last one, work out the request it causes
    task automatic fold_offer(input logic [31:0] word, input logic last);
        logic [31:0] mv, ma, mw;
        logic [9:0]  units;
        logic [2:0]  pos;
        logic        mismatch;
        request_t    req;
        if (word[31:30] == PDO_TYPE_FIXED) begin
            mv = 32'(word[19:10]) * 32'd50;
            ma = 32'(word[9:0]) * 32'd10;
            mw = (mv * ma + 32'd500) / 32'd1000;
            if (!(mw < 32'(best_mw) || (mw == 32'(best_mw) && mv > 32'(best_mv)))) begin
                best_mw     = mw[19:0];
                best_mv     = mv[15:0];
                best_ma     = ma[13:0];
                best_pos    = objects_seen + 3'd1;
                found_fixed = 1'b1;
            end
        end
        if (objects_seen < COUNT_LIMIT)
            objects_seen = objects_seen + 3'd1;
        if (last) begin
            if (found_fixed) begin
                units    = 10'(best_ma / 14'd10);
                pos      = best_pos;
                mismatch = 1'b0;
            end else begin
                units    = FALLBACK_UNITS;
                pos      = FALLBACK_POSITION;
                mismatch = 1'b1;
            end
            req.header  = header_bits | HDR_REQUEST_TYPE | HDR_ONE_OBJECT;
            req.rdo     = (32'(pos) << 28) | (32'(mismatch) << RDO_MISMATCH_BIT)
                        | (32'd1 << RDO_NO_SUSPEND_BIT) | (32'(units) << 10) | 32'(units);
            req.matched = found_fixed;
            pending_requests.push_back(req);
            best_mw      = '0;
            best_mv      = START_MV;
            best_ma      = '0;
            best_pos     = '0;
            found_fixed  = 1'b0;
            objects_seen = '0;
        end
    endtask

    // offer driver
    always @(posedge i_clk) begin
        offer_t next_offer;
        if (i_rst_n) begin
            if (i_offer_valid && o_offer_ready)
                fold_offer(i_offer_word, i_last_offer);
            if (!i_offer_valid || o_offer_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_offer_valid <= 1'b0;
                end else if (offer_queue.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
                    gap_left <= $urandom_range(0, 7);
                    i_offer_valid <= 1'b0;
                end else if (offer_queue.size() != 0) begin
                    next_offer = offer_queue.pop_front();
                    i_offer_valid <= 1'b1;
                    i_offer_word <= next_offer.word;
                    i_last_offer <= next_offer.last;
                end else begin
                    i_offer_valid <= 1'b0;
                end
            end
        end
    end

    // request receiver: one long hold-off on demand, otherwise short stalls
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_req_ready <= 1'b0;
        end else if (start_hold && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD - 1;
            i_req_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_req_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 7);
            i_req_ready <= 1'b0;
        end else begin
            i_req_ready <= 1'b1;
        end
    end

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    // request monitor
    always @(posedge i_clk) begin
        request_t want;
        if (i_rst_n && o_req_valid && i_req_ready) begin
            if (pending_requests.size() == 0) begin
                flag_mismatch("unexpected request object", '0, o_request_object);
            end else begin
                want = pending_requests.pop_front();
                if (o_request_header !== want.header)
                    flag_mismatch("request_header", 32'(want.header), 32'(o_request_header));
                if (o_request_object !== want.rdo)
                    flag_mismatch("request_object", want.rdo, o_request_object);
                if (o_matched !== want.matched)
                    flag_mismatch("matched", 32'(want.matched), 32'(o_matched));
            end
        end
    end

    function automatic logic [31:0] fixed_offer(input logic [9:0] volt_units,
                                                input logic [9:0] amp_units);
        return {PDO_TYPE_FIXED, 10'($urandom), volt_units, amp_units};
    endfunction

    task automatic queue_offer(input logic [31:0] word, input logic last);
        offer_t o;
        o.word = word;
        o.last = last;
        offer_queue.push_back(o);
    endtask

    function automatic logic [31:0] random_object();
        logic [9:0] volts[7] = '{10'd0, 10'd100, 10'd180, 10'd300, 10'd400, 10'd401, 10'd1023};
        logic [9:0] amps[5]  = '{10'd0, 10'd1, 10'd300, 10'd500, 10'd1023};
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return {2'($urandom_range(1, 3)), 30'($urandom)};
        else if (pick < 14)
            return $urandom;
        else if (pick < 40)
            return fixed_offer(volts[$urandom_range(0, 6)],
                               $urandom_range(0, 1) ? amps[$urandom_range(0, 4)]
                                                    : 10'($urandom));
        else
            return fixed_offer(10'($urandom), 10'($urandom));
    endfunction

    // queue whole capability messages until about n objects are pending
    task automatic queue_messages(input int n);
        int len;
        int queued;
        queued = 0;
        while (queued < n) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 7);
            for (int k = 0; k < len; k++)
                queue_offer(random_object(), k == len - 1);
            queued += len;
        end
    endtask

    // hold off until every transfer is done and the pipeline has emptied
    task automatic wait_drained();
        while (offer_queue.size() != 0 || i_offer_valid || pending_requests.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_template(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_header_template <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        header_bits = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fallback cases, extremes, ties, rounding, position saturation
        queue_offer({2'b01, 30'h0}, 1'b1);
        queue_offer(32'hFFFF_FFFF, 1'b1);
        queue_offer(fixed_offer(10'd0, 10'd0), 1'b1);
        queue_offer(fixed_offer(10'd401, 10'd0), 1'b1);
        queue_offer(32'h3FFF_FFFF, 1'b1);
        queue_offer(fixed_offer(10'd100, 10'd300), 1'b0);
        queue_offer(fixed_offer(10'd300, 10'd100), 1'b1);
        queue_offer(fixed_offer(10'd180, 10'd200), 1'b0);
        queue_offer(fixed_offer(10'd180, 10'd200), 1'b1);
        queue_offer({2'b10, 30'($urandom)}, 1'b0);
        queue_offer({2'b11, 30'($urandom)}, 1'b0);
        queue_offer(fixed_offer(10'd1, 10'd1), 1'b1);
        for (int k = 0; k < 9; k++)
            queue_offer(fixed_offer(10'd100, 10'(10 * (k + 1))), k == 8);
        wait_drained();

        // all template bits set; stall the receiver long enough to back up the input
        write_template(16'hFFFF);
        start_hold <= 1'b1;
        queue_messages(400);
        wait_drained();

        write_template(16'($urandom));
        queue_messages(450);
        wait_drained();

        // last stretch at full rate
        write_template(16'h0000);
        calm <= 1'b1;
        queue_messages(400);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
